/* design/mkh_pkg.sv */
// ----------------------------------------------------------------------------
// mkh_pkg
// Shared constants and types for the murmur64a key hash core: the mixing
// multiplier, its 32-bit halves, the partial-product pass codes and the
// request/response bundle of the shared multiply unit.
// ----------------------------------------------------------------------------
package mkh_pkg;

	// mixing multiplier and xor-shift distance
	localparam logic [63:0] MIX_MUL   = 64'hc6a4_a793_5bd1_e995;
	localparam int unsigned MIX_SHIFT = 47;

	// halves of the multiplier as seen by the 32x32 multiplier
	localparam logic [31:0] MUL_LO = MIX_MUL[31:0];
	localparam logic [31:0] MUL_HI = MIX_MUL[63:32];

	// partial-product passes of one 64-bit modular multiply
	localparam logic [1:0] PASS_LL = 2'd0;   // a_lo * m_lo, full 64 bits
	localparam logic [1:0] PASS_LH = 2'd1;   // a_lo * m_hi, low half into upper word
	localparam logic [1:0] PASS_HL = 2'd2;   // a_hi * m_lo, low half into upper word

	// request into the shared multiply unit
	typedef struct packed {
		logic        start;
		logic [63:0] operand;
	} mul_req_t;

	// response from the shared multiply unit
	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

endpackage

/* design/mkh_mul_unit.sv */
// ----------------------------------------------------------------------------
// mkh_mul_unit
// Shared modular multiplier: operand * MIX_MUL mod 2^64, built from one
// 32x32 multiplier used over three passes with a 64-bit accumulator.
// ----------------------------------------------------------------------------
module mkh_mul_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  mkh_pkg::mul_req_t req,
	output mkh_pkg::mul_rsp_t rsp
);

	logic        busy_q;
	logic [1:0]  pass_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_p;

	// operand half selection for the current pass
	always_comb begin
		mul_x = (pass_q == mkh_pkg::PASS_HL) ? a_q[63:32] : a_q[31:0];
		mul_y = (pass_q == mkh_pkg::PASS_LH) ? mkh_pkg::MUL_HI : mkh_pkg::MUL_LO;
		mul_p = mul_x * mul_y;
	end

	// pass sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= mkh_pkg::PASS_LL;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				pass_q <= mkh_pkg::PASS_LL;
			end else if (busy_q) begin
				if (pass_q == mkh_pkg::PASS_HL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				pass_q <= pass_q + 2'd1;
			end
		end
	end

	// operand capture and accumulation
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end
		if (busy_q) begin
			if (pass_q == mkh_pkg::PASS_LL) begin
				acc_q <= mul_p;
			end else begin
				acc_q <= acc_q + {mul_p[31:0], 32'd0};
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

	// no new request while passes are running
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiply started while busy");

	// the last pass ends in a done pulse unless a new start cuts it short
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && pass_q == mkh_pkg::PASS_HL) |=> rsp.done)
		else $error("missing done after last pass");

	// done is only flagged once the unit has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !busy_q)
		else $error("done while still busy");

endmodule

/* design/murmur64a_key_hash_core.sv */
// ----------------------------------------------------------------------------
// murmur64a_key_hash_core
// MurmurHash64A of a byte key streamed as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Every 64-bit multiply by the mixing constant goes through one shared 32x32
// multiplier in three passes; the block takes one word at a time and holds
// key_stall high while it works. A middle word runs two mixing multiplies
// and one hash multiply, a word with first_word first runs the length-seed
// multiply, and a last word adds the finalizer multiply and result hand-off.
// A last word with 1 to 7 valid bytes skips the mixing multiplies and one
// with 0 valid bytes runs only the finalizer. The result sits in an output
// register, so a new key word can be taken while hash_valid waits.
// ----------------------------------------------------------------------------
module murmur64a_key_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_stall,
	input  logic [63:0] key_word,
	input  logic [3:0]  valid_bytes,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [31:0] key_length,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [63:0] hash_value
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SEED = 8'b0000_0010,
		ST_WORD = 8'b0000_0100,
		ST_MIXA = 8'b0000_1000,
		ST_MIXB = 8'b0001_0000,
		ST_HMUL = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	mkh_pkg::mul_req_t mul_req;
	mkh_pkg::mul_rsp_t mul_rsp;

	logic        key_xfer;
	logic        out_free;
	logic [63:0] running_hash_q;
	logic [63:0] h_q;
	logic [63:0] word_q;
	logic [2:0]  nbytes_q;
	logic        last_q;
	logic        full_q;
	logic        skip_q;
	logic [63:0] res_q;
	logic        hash_valid_q;
	logic [63:0] hash_value_q;

	// h ^ (h >> 47)
	function automatic logic [63:0] xorshift(input logic [63:0] v);
		return v ^ (v >> mkh_pkg::MIX_SHIFT);
	endfunction

	// low-byte mask for a partial tail word
	function automatic logic [63:0] byte_mask(input logic [2:0] n);
		return ~({64{1'b1}} << {n, 3'b000});
	endfunction

	mkh_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign key_stall  = (state_q != ST_IDLE);
	assign key_xfer   = key_valid && !key_stall;
	assign out_free   = !hash_valid_q || !hash_stall;
	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

	// sequencer: next state and multiply requests
	always_comb begin
		state_d         = state_q;
		mul_req.start   = 1'b0;
		mul_req.operand = word_q;
		case (state_q)
			ST_IDLE: begin
				if (key_xfer) begin
					if (first_word) begin
						mul_req.start   = 1'b1;
						mul_req.operand = {32'd0, key_length};
						state_d         = ST_SEED;
					end else begin
						state_d = ST_WORD;
					end
				end
			end
			ST_SEED: begin
				if (mul_rsp.done) begin
					state_d = ST_WORD;
				end
			end
			ST_WORD: begin
				mul_req.start = 1'b1;
				if (skip_q) begin
					mul_req.operand = xorshift(h_q);
					state_d         = ST_FIN;
				end else if (full_q) begin
					mul_req.operand = word_q;
					state_d         = ST_MIXA;
				end else begin
					mul_req.operand = h_q ^ (word_q & byte_mask(nbytes_q));
					state_d         = ST_HMUL;
				end
			end
			ST_MIXA: begin
				if (mul_rsp.done) begin
					mul_req.start   = 1'b1;
					mul_req.operand = xorshift(mul_rsp.product);
					state_d         = ST_MIXB;
				end
			end
			ST_MIXB: begin
				if (mul_rsp.done) begin
					mul_req.start   = 1'b1;
					mul_req.operand = h_q ^ mul_rsp.product;
					state_d         = ST_HMUL;
				end
			end
			ST_HMUL: begin
				if (mul_rsp.done) begin
					if (last_q) begin
						mul_req.start   = 1'b1;
						mul_req.operand = xorshift(mul_rsp.product);
						state_d         = ST_FIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FIN: begin
				if (mul_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state, running hash and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			running_hash_q <= 64'd0;
			hash_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WORD && skip_q) begin
				running_hash_q <= h_q;
			end else if (state_q == ST_HMUL && mul_rsp.done) begin
				running_hash_q <= mul_rsp.product;
			end
			if (state_q == ST_EMIT && out_free) begin
				hash_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				hash_valid_q <= 1'b0;
			end
		end
	end

	// word capture and working hash
	always_ff @(posedge clk) begin
		if (key_xfer) begin
			word_q   <= key_word;
			nbytes_q <= valid_bytes[2:0];
			last_q   <= last_word;
			full_q   <= !last_word || valid_bytes[3];
			skip_q   <= last_word && (valid_bytes == 4'd0);
			h_q      <= running_hash_q;
		end else if (state_q == ST_SEED && mul_rsp.done) begin
			h_q <= mul_rsp.product;
		end
		if (state_q == ST_FIN && mul_rsp.done) begin
			res_q <= xorshift(mul_rsp.product);
		end
		if (state_q == ST_EMIT && out_free) begin
			hash_value_q <= res_q;
		end
	end

	// a multiply result only arrives while the sequencer waits for one
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_SEED || state_q == ST_MIXA ||
			state_q == ST_MIXB || state_q == ST_HMUL || state_q == ST_FIN))
		else $error("multiply result outside a wait state");

	// a new result is only loaded from the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(hash_valid && !$past(hash_valid)) |-> $past(state_q) == ST_EMIT)
		else $error("result loaded outside emit");

	// finalizer completion always leads to emit
	a_fin_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && mul_rsp.done) |=> state_q == ST_EMIT)
		else $error("finalizer did not reach emit");

endmodule

/* sim/murmur64a_key_hash_core_tb.sv */
// ----------------------------------------------------------------------------
// murmur64a_key_hash_core_tb
// Self-checking bench for the murmur64a key hash core. A short table of
// directed key words covers the empty key, zero-byte and oversized tails,
// tails of 1 to 4, 6 and 7 bytes, the ignored byte count on middle words,
// and words sent without a leading first word. Random keys follow: mostly
// well-formed word streams, with some broken streams and noise. Each accepted
// word goes through a bench-side hash model, and every hash_value transfer is
// compared in order against the queue of predicted hashes. Both sides
// idle in random bursts, and the final stretch runs with no idling.
// ----------------------------------------------------------------------------
module murmur64a_key_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_WORDS      = 1400;
	localparam int QUIET_AFTER    = 1250;
	localparam int DRAIN_AT       = 700;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        is_first;
		logic        is_last;
		logic [31:0] len;
	} key_item_t;

	logic        clk;
	logic        arst_n;
	logic        key_valid;
	logic        key_stall;
	logic [63:0] key_word;
	logic [3:0]  valid_bytes;
	logic        first_word;
	logic        last_word;
	logic [31:0] key_length;
	logic        hash_valid;
	logic        hash_stall;
	logic [63:0] hash_value;

	// bench-side hash state and predicted results
	logic [63:0] digest_state;
	logic [63:0] hash_expect_q[$];

	int  error_count;
	int  words_sent;
	int  idle_cycles;
	bit  quiet;
	int  sender_idle_pct;

	// directed table
	key_item_t   dir_item[$];
	bit          dir_typed[$];
	logic [63:0] dir_hash[$];

	murmur64a_key_hash_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key_word    (key_word),
		.valid_bytes (valid_bytes),
		.first_word  (first_word),
		.last_word   (last_word),
		.key_length  (key_length),
		.hash_valid  (hash_valid),
		.hash_stall  (hash_stall),
		.hash_value  (hash_value)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// full-word scramble: multiply, xor-shift, multiply
	function automatic logic [63:0] scramble_word(input logic [63:0] k);
		logic [63:0] t;
		t = k * mkh_pkg::MIX_MUL;
		t = t ^ (t >> mkh_pkg::MIX_SHIFT);
		t = t * mkh_pkg::MIX_MUL;
		return t;
	endfunction

	// absorb one key word into the digest, produce the hash on a last word
	function automatic void absorb_key_word(input key_item_t it, output bit has_hash,
			output logic [63:0] hash);
		logic [63:0] h;
		logic [63:0] mask;
		h = digest_state;
		if (it.is_first)
			h = {32'd0, it.len} * mkh_pkg::MIX_MUL;
		if (!it.is_last || it.nbytes >= 4'd8) begin
			h = h ^ scramble_word(it.word);
			h = h * mkh_pkg::MIX_MUL;
		end else if (it.nbytes != 4'd0) begin
			mask = (64'd1 << (int'(it.nbytes) * 8)) - 64'd1;
			h = h ^ (it.word & mask);
			h = h * mkh_pkg::MIX_MUL;
		end
		digest_state = h;
		has_hash = it.is_last;
		// finalizer
		h = h ^ (h >> mkh_pkg::MIX_SHIFT);
		h = h * mkh_pkg::MIX_MUL;
		h = h ^ (h >> mkh_pkg::MIX_SHIFT);
		hash = h;
	endfunction

	// present one word, hold it until the transfer, then maybe idle
	task automatic send_key_word(input key_item_t it, input bit typed,
			input logic [63:0] typed_hash);
		bit          has_hash;
		logic [63:0] h;
		key_valid   <= 1'b1;
		key_word    <= it.word;
		valid_bytes <= it.nbytes;
		first_word  <= it.is_first;
		last_word   <= it.is_last;
		key_length  <= it.len;
		@(posedge clk);
		while (key_stall)
			@(posedge clk);
		absorb_key_word(it, has_hash, h);
		if (has_hash)
			hash_expect_q.push_back(typed ? typed_hash : h);
		words_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(1, 100) <= sender_idle_pct) begin
			key_valid   <= 1'b0;
			key_word    <= {$urandom, $urandom};
			valid_bytes <= 4'($urandom);
			repeat ($urandom_range(1, 13))
				@(negedge clk);
		end
	endtask

	task automatic add_row(input logic [63:0] word, input logic [3:0] nbytes,
			input logic is_first, input logic is_last, input logic [31:0] len,
			input bit typed, input logic [63:0] typed_hash);
		key_item_t it;
		it.word     = word;
		it.nbytes   = nbytes;
		it.is_first = is_first;
		it.is_last  = is_last;
		it.len      = len;
		dir_item.push_back(it);
		dir_typed.push_back(typed);
		dir_hash.push_back(typed_hash);
	endtask

	// one random key: well-formed stream, broken stream or noise word
	task automatic send_random_key();
		key_item_t it;
		int        len_bytes;
		int        nwords;
		int        tail;
		int        pick;
		bit        empty_tail;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// noise word, every field random
			it.word     = {$urandom, $urandom};
			it.nbytes   = 4'($urandom);
			it.is_first = 1'($urandom);
			it.is_last  = 1'($urandom);
			it.len      = $urandom;
			send_key_word(it, 1'b0, 64'd0);
			return;
		end
		if (pick < 80)
			len_bytes = $urandom_range(0, 48);
		else
			len_bytes = $urandom_range(49, 200);
		if (len_bytes == 0) begin
			nwords = 1;
			tail   = 0;
		end else begin
			nwords = (len_bytes + 7) / 8;
			tail   = (len_bytes % 8 == 0) ? 8 : len_bytes % 8;
		end
		// broken streams: trailing empty word, or a length seed unrelated to the data
		empty_tail = (pick >= 90 && pick < 95);
		for (int i = 0; i < nwords; i++) begin
			it.word     = {$urandom, $urandom};
			it.is_first = (i == 0);
			it.is_last  = (i == nwords - 1) && !empty_tail;
			it.nbytes   = it.is_last ? 4'(tail) : 4'($urandom);
			it.len      = (i == 0) ? ((pick >= 95) ? $urandom : 32'(len_bytes)) : $urandom;
			send_key_word(it, 1'b0, 64'd0);
		end
		if (empty_tail) begin
			it.word     = {$urandom, $urandom};
			it.nbytes   = 4'd0;
			it.is_first = 1'b0;
			it.is_last  = 1'b1;
			it.len      = $urandom;
			send_key_word(it, 1'b0, 64'd0);
		end
	endtask

	// stimulus and end of run
	initial begin
		bit drained;
		arst_n          = 1'b0;
		key_valid       = 1'b0;
		key_word        = '0;
		valid_bytes     = '0;
		first_word      = 1'b0;
		last_word       = 1'b0;
		key_length      = '0;
		hash_stall      = 1'b0;
		digest_state    = '0;
		error_count     = 0;
		words_sent      = 0;
		quiet           = 1'b0;
		sender_idle_pct = 25;
		drained         = 1'b0;

		// empty tail right after reset, empty key
		add_row(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 64'd0);
		add_row(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'd0);
		// largest length seed, middle word with byte count ignored
		add_row(64'd0, 4'd0, 1'b1, 1'b0, 32'hffff_ffff, 1'b0, 64'd0);
		add_row(64'hffff_ffff_ffff_ffff, 4'd5, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0);
		add_row(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, 32'hffff_ffff, 1'b0, 64'd0);
		// tails of 1 and 7 bytes, oversized byte counts
		add_row(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 64'd0);
		add_row(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, 64'd0);
		add_row(64'h8000_0000_0000_0001, 4'd9, 1'b1, 1'b1, 32'd9, 1'b0, 64'd0);
		add_row(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b1, 32'd15, 1'b0, 64'd0);
		// length not matching the words
		add_row(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b0, 32'd8, 1'b0, 64'd0);
		add_row(64'hfedc_ba98_7654_3210, 4'd3, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0);
		// continue from the kept digest with no first word
		add_row(64'h5a5a_5a5a_5a5a_5a5a, 4'd2, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0);
		// two full words then an empty last word
		add_row(64'd1, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, 64'd0);
		add_row(64'd2, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0);
		add_row(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0);
		add_row(64'd0, 4'd4, 1'b1, 1'b1, 32'hffff_ffff, 1'b0, 64'd0);
		add_row(64'ha5a5_a5a5_a5a5_a5a5, 4'd6, 1'b1, 1'b1, 32'd0, 1'b0, 64'd0);

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < dir_item.size(); i++)
			send_key_word(dir_item[i], dir_typed[i], dir_hash[i]);

		while (words_sent < KEY_WORDS) begin
			if ($urandom_range(0, 7) == 0)
				sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
			if (words_sent >= QUIET_AFTER)
				quiet = 1'b1;
			// hold off until every predicted hash has come out
			if (!drained && words_sent >= DRAIN_AT) begin
				key_valid <= 1'b0;
				while (hash_expect_q.size() != 0)
					@(negedge clk);
				drained = 1'b1;
			end
			send_random_key();
		end

		key_valid <= 1'b0;
		while (hash_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("murmur64a_key_hash_core verification clean");
		else
			$display("murmur64a_key_hash_core verification failed");
		$finish;
	end

	// result-side stall bursts, none in the final stretch
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				hash_stall <= 1'b1;
				repeat ($urandom_range(1, 13))
					@(negedge clk);
				hash_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(0, 30))
					@(negedge clk);
			end
		end
	end

	// compare each hash transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && hash_valid && !hash_stall) begin
			if (hash_expect_q.size() == 0) begin
				$display("%0t: unexpected hash_value transfer, expected none, actual %h",
					$time, hash_value);
				error_count++;
			end else begin
				if (hash_value !== hash_expect_q[0]) begin
					$display("%0t: hash_value mismatch, expected %h, actual %h",
						$time, hash_expect_q[0], hash_value);
					error_count++;
				end
				void'(hash_expect_q.pop_front());
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (key_valid && !key_stall) || (hash_valid && !hash_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("murmur64a_key_hash_core verification failed");
				$finish;
			end
		end
	end

endmodule

/* files.f */
design/mkh_pkg.sv
design/mkh_mul_unit.sv
design/murmur64a_key_hash_core.sv
sim/murmur64a_key_hash_core_tb.sv
